>>> rtl/euler_totient_macros.svh
// Assertion macros shared by the euler_totient RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef EULER_TOTIENT_MACROS_SVH
`define EULER_TOTIENT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ET_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ET_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/et_pkg.sv
// Package for the euler_totient block: widths, state and command types.
// No dependencies.
package et_pkg;

  localparam int WIDTH = 32;
  localparam int DW    = WIDTH / 2 + 1;
  localparam int CW    = $clog2(WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_EVAL,
    S_FINAL,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_DM1,
    MUL_D,
    MUL_NM1
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     div_step;
    logic     take_q;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     d_inc;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic d_gt_q;
    logic rem_zero;
    logic n_gt1;
  } sts_t;

endpackage

>>> rtl/et_dpath.sv
// Datapath: residual n, candidate d, accumulator, restoring divider, output register.
// Depends on et_pkg and euler_totient_macros.svh.
`include "euler_totient_macros.svh"

module et_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  et_pkg::cmd_t               cmd,
  output et_pkg::sts_t               sts,
  input  logic [et_pkg::WIDTH-1:0]   value,
  output logic [et_pkg::WIDTH-1:0]   totient
);

  logic [et_pkg::WIDTH-1:0]   n;
  logic [et_pkg::WIDTH-1:0]   n_next;
  logic [et_pkg::DW-1:0]      d;
  logic [et_pkg::WIDTH-1:0]   acc;
  logic [et_pkg::WIDTH-1:0]   quo;
  logic [et_pkg::DW-1:0]      rem;
  logic [et_pkg::CW-1:0]      cnt;
  logic [et_pkg::DW:0]        rem_sh;
  logic [et_pkg::DW:0]        rem_sub;
  logic                       ge;
  logic [et_pkg::WIDTH-1:0]   mul_op;
  logic [2*et_pkg::WIDTH-1:0] prod;

  assign rem_sh  = {rem, quo[et_pkg::WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, d};
  assign ge      = rem_sh >= {1'b0, d};

  always_comb begin
    if (cmd.load) begin
      n_next = value;
    end else if (cmd.take_q) begin
      n_next = quo;
    end else begin
      n_next = n;
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      et_pkg::MUL_DM1: mul_op = et_pkg::WIDTH'(d) - et_pkg::WIDTH'(1);
      et_pkg::MUL_D:   mul_op = et_pkg::WIDTH'(d);
      et_pkg::MUL_NM1: mul_op = n - et_pkg::WIDTH'(1);
      default:         mul_op = et_pkg::WIDTH'(1);
    endcase
  end

  assign prod = acc * mul_op;

  always_ff @(posedge clk) begin
    n <= n_next;
    if (cmd.load) begin
      d   <= et_pkg::DW'(2);
      acc <= et_pkg::WIDTH'(1);
    end else begin
      if (cmd.d_inc) begin
        d <= d + et_pkg::DW'(1);
      end
      if (cmd.mul_en) begin
        acc <= prod[et_pkg::WIDTH-1:0];
      end
    end
    if (cmd.div_start) begin
      quo <= n_next;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[et_pkg::WIDTH-2:0], ge};
      rem <= ge ? rem_sub[et_pkg::DW-1:0] : rem_sh[et_pkg::DW-1:0];
      cnt <= cnt + et_pkg::CW'(1);
    end
    if (cmd.out_load) begin
      totient <= acc;
    end
  end

  assign sts.div_last = cnt == et_pkg::CW'(et_pkg::WIDTH - 1);
  assign sts.d_gt_q   = et_pkg::WIDTH'(d) > quo;
  assign sts.rem_zero = rem == '0;
  assign sts.n_gt1    = n > et_pkg::WIDTH'(1);

  `ET_ASSERT_IMP(a_div_nonzero, clk, rst, cmd.div_step, d != '0)
  `ET_ASSERT_NXT(a_load_init, clk, rst, cmd.load, acc == 1 && d == 2 && cnt == 0)

endmodule

>>> rtl/et_ctrl.sv
// Controller state machine: sequences divisions, multiplies and the output handshake.
// Depends on et_pkg and euler_totient_macros.svh.
`include "euler_totient_macros.svh"

module et_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output et_pkg::cmd_t cmd,
  input  et_pkg::sts_t sts
);

  et_pkg::state_t state;
  et_pkg::state_t state_next;
  logic           inner;
  logic           inner_next;
  logic           out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= et_pkg::S_IDLE;
      inner     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      inner     <= inner_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    inner_next     = inner;
    out_valid_next = out_valid & ~out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mul_sel    = et_pkg::MUL_D;
    unique case (state)
      et_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load      = 1'b1;
          cmd.div_start = 1'b1;
          inner_next    = 1'b0;
          state_next    = et_pkg::S_DIV;
        end
      end
      et_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = et_pkg::S_EVAL;
        end
      end
      et_pkg::S_EVAL: begin
        if (inner) begin
          cmd.div_start = 1'b1;
          state_next    = et_pkg::S_DIV;
          if (sts.rem_zero) begin
            cmd.take_q  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = et_pkg::MUL_D;
          end else begin
            cmd.d_inc  = 1'b1;
            inner_next = 1'b0;
          end
        end else if (sts.d_gt_q) begin
          state_next = et_pkg::S_FINAL;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = et_pkg::S_DIV;
          if (sts.rem_zero) begin
            cmd.take_q  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = et_pkg::MUL_DM1;
            inner_next  = 1'b1;
          end else begin
            cmd.d_inc = 1'b1;
          end
        end
      end
      et_pkg::S_FINAL: begin
        cmd.mul_en  = sts.n_gt1;
        cmd.mul_sel = et_pkg::MUL_NM1;
        state_next  = et_pkg::S_OUT;
      end
      et_pkg::S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = et_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = et_pkg::S_IDLE;
      end
    endcase
  end

  `ET_ASSERT_NXT(a_div_holds, clk, rst, state == et_pkg::S_DIV && !sts.div_last, state == et_pkg::S_DIV)
  `ET_ASSERT_NXT(a_out_issue, clk, rst, state == et_pkg::S_OUT && (!out_valid || out_ready), out_valid && state == et_pkg::S_IDLE)

endmodule

>>> rtl/euler_totient.sv
// Euler totient unit: one unsigned value in, phi(value) out.
// Channels: in_valid/in_ready carry value; out_valid/out_ready carry totient.
// Each transaction on the input yields exactly one transaction on the output.
// The block works on one value at a time. Prime factors are found by trial
// division with candidates d = 2, 3, ... while d <= n/d; every division runs
// through a restoring divider (S_DIV) followed by an evaluate state (S_EVAL).
// Inputs 0 and 1 finish with totient 1. The result sits in an output
// register; in_ready rises again as soon as the result is loaded, so the
// next value is taken while the receiver stalls. A finished result waits
// for the previous one to be taken before loading.
// Synchronous reset returns the controller to idle and drops out_valid.
// Depends on et_pkg, et_ctrl and et_dpath.
module euler_totient (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [et_pkg::WIDTH-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [et_pkg::WIDTH-1:0] totient
);

  et_pkg::cmd_t cmd;
  et_pkg::sts_t sts;

  et_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  et_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .value   (value),
    .totient (totient)
  );

endmodule

>>> tb/tb_euler_totient.sv
// Testbench for euler_totient: directed table then random values. Known rows
// are checked against their typed totient, the rest against a trial-division
// predictor in the bench. Depends on et_pkg and the euler_totient RTL.
`timescale 1ns / 100ps

module tb_euler_totient;

  localparam int W = et_pkg::WIDTH;
  localparam logic [63:0] VMAX = (64'd1 << W) - 1;
  localparam int N_RANDOM = 100;

  typedef struct packed {
    logic [W-1:0] value;
    logic         known;
    logic [W-1:0] totient;
  } stim_row_t;

  typedef struct packed {
    logic [W-1:0] value;
    logic [W-1:0] totient;
  } phi_rec_t;

  localparam int N_DIRECTED = 20;
  localparam stim_row_t DIR_ROWS [N_DIRECTED] = '{
    '{32'd0,          1'b1, 32'd1},
    '{32'd1,          1'b1, 32'd1},
    '{32'd2,          1'b1, 32'd1},
    '{32'd3,          1'b1, 32'd2},
    '{32'd4,          1'b0, 32'd0},
    '{32'd6,          1'b0, 32'd0},
    '{32'd9,          1'b0, 32'd0},
    '{32'd12,         1'b0, 32'd0},
    '{32'd251,        1'b0, 32'd0},
    '{32'd63001,      1'b0, 32'd0},
    '{32'd65521,      1'b1, 32'd65520},
    '{32'd65536,      1'b1, 32'd32768},
    '{32'd131042,     1'b0, 32'd0},
    '{32'd223092870,  1'b0, 32'd0},
    '{32'h8000_0000,  1'b1, 32'h4000_0000},
    '{32'hFFFF_FFFF,  1'b1, 32'h8000_0000},
    '{32'hAAAA_AAAA,  1'b0, 32'd0},
    '{32'h5555_5555,  1'b0, 32'd0},
    '{32'd3486784401, 1'b0, 32'd0},
    '{32'd4293918735, 1'b0, 32'd0}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [W-1:0] value = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [W-1:0] totient;

  phi_rec_t phi_expected [$];
  int       mismatch_count = 0;
  bit       send_burst = 1'b0;
  bit       recv_burst = 1'b0;

  euler_totient DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .totient  (totient)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [W-1:0] phi_of(input logic [W-1:0] v);
    logic [63:0] n;
    logic [63:0] acc;
    logic [63:0] d;
    n   = 64'(v);
    acc = 64'd1;
    for (d = 64'd2; d <= n / d; d++) begin
      if (n % d == 0) begin
        n   = n / d;
        acc = acc * (d - 1);
        while (n % d == 0) begin
          n   = n / d;
          acc = acc * d;
        end
      end
    end
    if (n > 1)
      acc = acc * (n - 1);
    return acc[W-1:0];
  endfunction

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_value(input logic [W-1:0] v, input logic known,
                            input logic [W-1:0] typed_phi);
    int       gap;
    phi_rec_t rec;
    if ($urandom_range(0, 15) == 0)
      send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    rec.value   = v;
    rec.totient = known ? typed_phi : phi_of(v);
    phi_expected = {phi_expected, rec};
  endtask

  // result side
  initial begin
    int       stall;
    phi_rec_t rec;
    logic [W-1:0] got;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0)
        recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      got = totient;
      if (phi_expected.size() == 0) begin
        $display("%0t: unexpected totient transaction: expected none, actual %0d",
                 $time, got);
        mismatch_count++;
      end else begin
        rec = phi_expected.pop_front();
        if (got !== rec.totient) begin
          $display("%0t: totient of %0d: expected %0d, actual %0d",
                   $time, rec.value, rec.totient, got);
          mismatch_count++;
        end
      end
      @(posedge clk);
    end
  end

  // value side
  initial begin
    logic [63:0]  prod;
    logic [63:0]  f;
    logic [W-1:0] v;
    int           kind;
    int           tries;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECTED; i++)
      send_value(DIR_ROWS[i].value, DIR_ROWS[i].known, DIR_ROWS[i].totient);
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 0 || k == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        while (phi_expected.size() != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 19);
      if (kind < 9) begin
        prod = 64'($urandom_range(0, 16'hFFFF));
      end else if (kind < 19) begin
        // smooth values up to full width, some with one 16-bit cofactor
        prod  = (kind >= 15) ? 64'($urandom_range(2, 16'hFFFF)) : 64'd1;
        tries = $urandom_range(1, 40);
        repeat (tries) begin
          f = 64'($urandom_range(2, 255));
          if (prod * f <= VMAX)
            prod = prod * f;
        end
      end else begin
        prod = 64'($urandom_range(0, 20'hFFFFF));
      end
      v = prod[W-1:0];
      send_value(v, 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (phi_expected.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && phi_expected.size() == 0) begin
      $display("** euler_totient: PASSED **");
    end else begin
      $display("** euler_totient: FAILED **");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("%0t: timeout", $time);
    $display("** euler_totient: FAILED **");
    $finish;
  end

endmodule
